### sv/ctc_lattice_cell_update_core_assert.svh
// ----------------------------------------------------------------------------
// ctc lattice cell update - assertion macros
// property wrappers used by the core to check itself
// ----------------------------------------------------------------------------
`ifndef CTC_LATTICE_CELL_UPDATE_CORE_ASSERT_SVH
`define CTC_LATTICE_CELL_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CTC_LCU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CTC_LCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ctc_lcu_pkg.sv
// ----------------------------------------------------------------------------
// ctc lattice cell update - package
// number format, table constants, stage map and shared types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctc_lcu_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_TIME   = 1024;
	localparam int MAX_LABELS = 256;

	localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
	localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;

	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	localparam int ND_W = FRAC_BITS + 6;
	localparam int Y_W  = ND_W + 31 - FRAC_BITS;
	localparam int LN_W = FRAC_BITS + 2;

	localparam int EXP_STEPS  = 16;
	localparam int EXP_STAGES = EXP_STEPS + 2;
	localparam int LN_STEPS   = 30;
	localparam int LN_STAGES  = LN_STEPS + 1;

	localparam int ST_MAX   = 2;
	localparam int ST_EXP0  = 4;
	localparam int ST_SUM   = ST_EXP0 + EXP_STAGES;
	localparam int ST_LN0   = ST_SUM + 1;
	localparam int ST_FIN   = ST_LN0 + LN_STAGES;
	localparam int N_STAGES = ST_FIN + 1;

	// 2^(-2^-i), i = 1..16, q1.30
	localparam logic [29:0] POW2_NEG [EXP_STEPS] = '{
		30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
		30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
		30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135,
		30'd1073650976, 30'd1073696399, 30'd1073719111, 30'd1073730468};

	localparam logic [1:0] KIND_NEG = 2'd0;
	localparam logic [1:0] KIND_LP  = 2'd1;
	localparam logic [1:0] KIND_LSE = 2'd2;

	localparam logic [1:0] LOSS_NONE  = 2'd0;
	localparam logic [1:0] LOSS_BLANK = 2'd1;
	localparam logic [1:0] LOSS_LABEL = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         loss;
		logic signed [31:0] m;
		logic signed [31:0] lp;
		logic signed [31:0] prior;
		logic               skip;
		logic               sum_low;
	} side_t;

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v <= 34'(NEG_INF)) begin
			r = NEG_INF;
		end else if (v > 34'(POS_MAX)) begin
			r = POS_MAX;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### sv/ctc_lattice_cell_update_core.sv
// ----------------------------------------------------------------------------
// ctc lattice cell update - top level
// one log-domain ctc lattice cell per beat, forward or backward pass
// ----------------------------------------------------------------------------
//  channel  | signals                     | beat
//  ---------+-----------------------------+----------------------------------
//  s_       | tvalid tready tdata[207:0]  | one lattice cell request
//  m_       | tvalid tready tdata[71:0]   | cell value, store update, loss
//  cfg_     | wr_en wr_data               | pass select, 0 alpha 1 beta
//
// one beat enters per cycle whenever the pipeline advances; the fixed stage
// map is window, max, difference, 18 exp stages, sum, 31 log stages,
// result, store, output buffer
// the whole pipeline advances together; a two-entry output buffer lets it
// keep taking beats while one result waits
// arst_n clears valid bits, buffer count and the pass select
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_lattice_cell_update_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// time_step, slot_index, input_length, target_length, prev_same,
	// prev_minus_one, prev_minus_two, skip_allowed, label_logprob, store_prior
	input  logic [207:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cell_value, store_updated, loss_slot
	output logic [71:0]  m_tdata
);

	localparam int N = ctc_lcu_pkg::N_STAGES;

	logic direction_q;

	logic [9:0]         time_step, slot_index;
	logic [10:0]        input_length, ilen_c;
	logic [8:0]         target_length, tlen_c;
	logic signed [31:0] opd_in [3];
	logic               skip_allowed;
	logic signed [31:0] label_logprob, store_prior;

	logic signed [12:0] t_x, slot_x, ilen_x, seq_x, rem_x, start_x, wend_x, tw_x;
	logic               in_win, last_t, filled;
	ctc_lcu_pkg::side_t side_c;

	logic               adv;
	logic [N:1]         vld_s;
	ctc_lcu_pkg::side_t side_s  [1:N];
	ctc_lcu_pkg::side_t side_nx [2:N];

	logic signed [31:0] opd_s1 [3];
	logic signed [31:0] opd_s2 [3];
	logic signed [31:0] m_c;
	logic [ctc_lcu_pkg::ND_W-1:0] nd_s3 [3];
	logic               zero_s3 [3];
	logic [30:0]        e_out [3];

	logic [31:0]        sum_c;
	logic               low_c;
	logic [30:0]        z_s22;
	logic               int_s22;
	logic [ctc_lcu_pkg::LN_W-1:0] ln_out;

	logic signed [31:0] cell_s54, cell_s55, upd_s55;
	logic signed [33:0] lse_sum;

	logic [71:0]        out_d, head_q, tail_q;
	logic [1:0]         cnt_q;
	logic               push, pop;

	assign time_step     = s_tdata[9:0];
	assign slot_index    = s_tdata[19:10];
	assign input_length  = s_tdata[30:20];
	assign target_length = s_tdata[39:31];
	assign opd_in[0]     = s_tdata[71:40];
	assign opd_in[1]     = s_tdata[103:72];
	assign opd_in[2]     = s_tdata[135:104];
	assign skip_allowed  = s_tdata[136];
	assign label_logprob = s_tdata[168:137];
	assign store_prior   = s_tdata[200:169];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_wr_en) begin
			direction_q <= cfg_wr_data;
		end
	end

	// time and slot window
	always_comb begin
		ilen_c  = (input_length > 11'(ctc_lcu_pkg::MAX_TIME)) ?
			11'(ctc_lcu_pkg::MAX_TIME) : input_length;
		tlen_c  = (target_length > 9'(ctc_lcu_pkg::MAX_LABELS)) ?
			9'(ctc_lcu_pkg::MAX_LABELS) : target_length;
		t_x     = 13'($unsigned(time_step));
		slot_x  = 13'($unsigned(slot_index));
		ilen_x  = 13'($unsigned(ilen_c));
		seq_x   = 13'($unsigned({tlen_c, 1'b1}));
		rem_x   = ilen_x - t_x;
		start_x = (rem_x > 13'sd0 && seq_x > (rem_x <<< 1)) ? seq_x - (rem_x <<< 1) : 13'sd0;
		tw_x    = (t_x <<< 1) + 13'sd2;
		wend_x  = (tw_x < seq_x) ? tw_x : seq_x;
		in_win  = slot_x < seq_x && slot_x >= start_x && slot_x <= wend_x;
		last_t  = (t_x + 13'sd1) == ilen_x;

		side_c       = '0;
		side_c.lp    = label_logprob;
		side_c.prior = store_prior;
		side_c.skip  = skip_allowed;
		side_c.kind  = ctc_lcu_pkg::KIND_NEG;
		side_c.loss  = ctc_lcu_pkg::LOSS_NONE;
		filled       = 1'b0;
		if (!direction_q) begin
			if (t_x == 13'sd0) begin
				if (slot_x < 13'sd2) begin
					side_c.kind = ctc_lcu_pkg::KIND_LP;
				end
				filled = 1'b1;
			end else if (in_win && t_x < ilen_x) begin
				side_c.kind = ctc_lcu_pkg::KIND_LSE;
				filled      = 1'b1;
			end
			if (filled && last_t) begin
				if (slot_x == seq_x - 13'sd1) begin
					side_c.loss = ctc_lcu_pkg::LOSS_BLANK;
				end else if (slot_x == seq_x - 13'sd2) begin
					side_c.loss = ctc_lcu_pkg::LOSS_LABEL;
				end
			end
		end else begin
			if (last_t && (slot_x == seq_x - 13'sd1 || slot_x == seq_x - 13'sd2)) begin
				side_c.kind = ctc_lcu_pkg::KIND_LP;
			end else if (in_win && (t_x + 13'sd1) < ilen_x) begin
				side_c.kind = ctc_lcu_pkg::KIND_LSE;
			end
		end
	end

	// output buffer and global advance
	assign pop      = m_tvalid && m_tready;
	assign adv      = (cnt_q != 2'd2) || m_tready;
	assign push     = adv && vld_s[N];
	assign s_tready = adv;
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = head_q;
	assign out_d    = {6'd0, side_s[N].loss, upd_s55, cell_s55};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			cnt_q <= 2'd0;
		end else begin
			if (adv) begin
				vld_s <= {vld_s[N-1:1], s_tvalid};
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= out_d;
				end else begin
					tail_q <= out_d;
				end
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= out_d;
				end else begin
					head_q <= tail_q;
					tail_q <= out_d;
				end
			end
			default: head_q <= head_q;
		endcase
	end

	// running max of the neighbors
	always_comb begin
		m_c = (opd_s1[0] > opd_s1[1]) ? opd_s1[0] : opd_s1[1];
		if (side_s[1].skip && opd_s1[2] > m_c) begin
			m_c = opd_s1[2];
		end
	end

	// neighbor sum, normalized into [1,2)
	assign sum_c = {1'b0, e_out[0]} + {1'b0, e_out[1]} +
		(side_s[ctc_lcu_pkg::ST_SUM-1].skip ? {1'b0, e_out[2]} : 32'd0);
	assign low_c = sum_c[31:30] == 2'b00;

	always_comb begin
		for (int i = 2; i <= N; i++) begin
			side_nx[i] = side_s[i-1];
		end
		side_nx[ctc_lcu_pkg::ST_MAX].m       = m_c;
		side_nx[ctc_lcu_pkg::ST_SUM].sum_low = low_c;
	end

	assign lse_sum = 34'($unsigned(ln_out)) + 34'(side_s[N-2].m) + 34'(side_s[N-2].lp);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side_c;
			for (int i = 2; i <= N; i++) begin
				side_s[i] <= side_nx[i];
			end
			opd_s1 <= opd_in;
			opd_s2 <= opd_s1;
			z_s22   <= sum_c[31] ? sum_c[31:1] : sum_c[30:0];
			int_s22 <= sum_c[31];

			unique case (side_s[N-2].kind)
				ctc_lcu_pkg::KIND_LP: cell_s54 <= side_s[N-2].lp;
				ctc_lcu_pkg::KIND_LSE: begin
					if (side_s[N-2].m == ctc_lcu_pkg::NEG_INF || side_s[N-2].sum_low ||
						side_s[N-2].lp == ctc_lcu_pkg::NEG_INF) begin
						cell_s54 <= ctc_lcu_pkg::NEG_INF;
					end else begin
						cell_s54 <= ctc_lcu_pkg::sat34(lse_sum);
					end
				end
				default: cell_s54 <= ctc_lcu_pkg::NEG_INF;
			endcase

			cell_s55 <= cell_s54;
			if (cell_s54 == ctc_lcu_pkg::NEG_INF ||
				side_s[N-1].prior == ctc_lcu_pkg::NEG_INF) begin
				upd_s55 <= ctc_lcu_pkg::NEG_INF;
			end else begin
				upd_s55 <= ctc_lcu_pkg::sat34(34'(side_s[N-1].prior) + 34'(cell_s54));
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_opd
		logic signed [33:0] diff;
		assign diff = 34'(side_s[ctc_lcu_pkg::ST_MAX].m) - 34'(opd_s2[k]);

		always_ff @(posedge clk) begin
			if (adv) begin
				nd_s3[k]   <= diff[ctc_lcu_pkg::ND_W-1:0];
				zero_s3[k] <= opd_s2[k] == ctc_lcu_pkg::NEG_INF || diff < 34'sd0 ||
					diff > (34'sd32 <<< ctc_lcu_pkg::FRAC_BITS);
			end
		end

		ctc_lcu_exp_pipe u_exp (
			.clk  (clk),
			.en   (adv),
			.nd   (nd_s3[k]),
			.zero (zero_s3[k]),
			.e    (e_out[k])
		);
	end

	ctc_lcu_ln_pipe u_ln (
		.clk    (clk),
		.en     (adv),
		.z_in   (z_s22),
		.int_in (int_s22),
		.ln_out (ln_out)
	);

	`include "ctc_lattice_cell_update_core_assert.svh"

	`CTC_LCU_ASSERT_SAME(a_empty_ready, !m_tvalid, s_tready, "ready low with empty buffer")
	`CTC_LCU_ASSERT_NEXT(a_accept_valid, s_tvalid && s_tready, vld_s[1], "accepted beat lost")
	`CTC_LCU_ASSERT_SAME(a_neg_store, m_tvalid && m_tdata[31:0] == 32'h8000_0000,
		m_tdata[63:32] == 32'h8000_0000, "store update not minus infinity")
	`CTC_LCU_ASSERT_NEXT(a_push_hold, push && !pop, m_tvalid, "pushed result not shown")

endmodule

### sv/ctc_lcu_exp_pipe.sv
// ----------------------------------------------------------------------------
// ctc lattice cell update - exp pipeline
// exp(-nd) in q1.30 by a base-2 product of table factors, one factor a stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_lcu_exp_pipe (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ctc_lcu_pkg::ND_W-1:0]     nd,
	input  logic                             zero,
	output logic [30:0]                      e
);

	localparam int STEPS = ctc_lcu_pkg::EXP_STEPS;
	localparam int YW    = ctc_lcu_pkg::Y_W;

	logic [ctc_lcu_pkg::ND_W+30:0] prod0;
	logic [YW-1:0]                 y;
	logic [YW-31:0]                kint;

	logic [30:0]      r_s    [0:STEPS];
	logic [STEPS-1:0] frac_s [0:STEPS];
	logic [4:0]       k_s    [0:STEPS];
	logic             zero_s [0:STEPS];

	assign prod0 = nd * ctc_lcu_pkg::LOG2E_Q30;
	assign y     = prod0[ctc_lcu_pkg::ND_W+30:ctc_lcu_pkg::FRAC_BITS];
	assign kint  = y[YW-1:30];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= ctc_lcu_pkg::ONE_Q30;
			frac_s[0] <= y[29:30-STEPS];
			k_s[0]    <= kint[4:0];
			zero_s[0] <= zero || (kint >= (YW-30)'(31));
		end
	end

	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		logic [60:0] prod;
		assign prod = r_s[j-1] * ctc_lcu_pkg::POW2_NEG[j-1];
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]    <= frac_s[j-1][STEPS-j] ? prod[60:30] : r_s[j-1];
				frac_s[j] <= frac_s[j-1];
				k_s[j]    <= k_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e <= zero_s[STEPS] ? 31'd0 : (r_s[STEPS] >> k_s[STEPS]);
		end
	end

endmodule

### sv/ctc_lcu_ln_pipe.sv
// ----------------------------------------------------------------------------
// ctc lattice cell update - log pipeline
// log2 fraction by repeated squaring, one bit a stage, then scaled by ln2
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_lcu_ln_pipe (
	input  logic                             clk,
	input  logic                             en,
	input  logic [30:0]                      z_in,
	input  logic                             int_in,
	output logic [ctc_lcu_pkg::LN_W-1:0]     ln_out
);

	localparam int STEPS = ctc_lcu_pkg::LN_STEPS;
	localparam int F     = ctc_lcu_pkg::FRAC_BITS;

	logic [30:0]      z_s    [0:STEPS];
	logic [STEPS-1:0] frac_s [0:STEPS];
	logic             int_s  [0:STEPS];
	logic [30:0]      l2;
	logic [61:0]      prod;

	assign z_s[0]    = z_in;
	assign frac_s[0] = '0;
	assign int_s[0]  = int_in;

	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		logic [61:0] sq;
		logic [31:0] q;
		assign sq = z_s[j-1] * z_s[j-1];
		assign q  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[j]    <= q[31] ? q[31:1] : q[30:0];
				frac_s[j] <= frac_s[j-1] | (STEPS'(q[31]) << (STEPS - j));
				int_s[j]  <= int_s[j-1];
			end
		end
	end

	assign l2   = {int_s[STEPS], frac_s[STEPS]};
	assign prod = 62'(l2) * 62'(ctc_lcu_pkg::LN2_Q30) + (62'd1 << (59 - F));

	always_ff @(posedge clk) begin
		if (en) begin
			ln_out <= prod[61:60-F];
		end
	end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// ctc lattice cell update - testbench
// streams lattice cells through the core in forward and backward passes;
// a directed table covers first and last steps, window edges, minus
// infinity and saturation, then random cells follow in bursts against a
// stalling receiver; every result beat is checked against a local model
// or, for typed table rows, against the expected values in the table
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic [9:0]         t;
		logic [9:0]         slot;
		logic [10:0]        ilen;
		logic [8:0]         tlen;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic               skip;
		logic signed [31:0] lp;
		logic signed [31:0] prior;
	} cell_req_t;

	typedef struct {
		logic signed [31:0] cell_val;
		logic signed [31:0] upd;
		logic [1:0]         loss;
	} cell_res_t;

	typedef struct {
		cell_req_t req;
		bit        typed;
		cell_res_t res;
	} table_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic         cfg_wr_data = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [207:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;

	logic      pass_dir = 1'b0;
	cell_res_t pending_cells[$];
	int        mismatches = 0;
	int        rx_cycle = 0;
	int        rx_mode = 0;

	ctc_lattice_cell_update_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clamp32(longint v);
		if (v <= -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		return v;
	endfunction

	// exp(x - m) in q1.30
	function automatic longint unsigned exp_q30(longint x, longint m);
		longint nd;
		longint unsigned y, k, r;
		if (x == longint'(ctc_lcu_pkg::NEG_INF)) begin
			return 0;
		end
		nd = m - x;
		if (nd < 0) begin
			nd = 0;
		end
		if (nd > (longint'(32) <<< ctc_lcu_pkg::FRAC_BITS)) begin
			return 0;
		end
		y = (longint'(nd) * longint'(ctc_lcu_pkg::LOG2E_Q30)) >> ctc_lcu_pkg::FRAC_BITS;
		k = y >> 30;
		if (k >= 31) begin
			return 0;
		end
		r = 64'd1 << 30;
		for (int i = 0; i < ctc_lcu_pkg::EXP_STEPS; i++) begin
			if (y[29 - i]) begin
				r = (r * longint'(ctc_lcu_pkg::POW2_NEG[i])) >> 30;
			end
		end
		return r >> k;
	endfunction

	function automatic longint ln_frac(longint unsigned s);
		longint unsigned z, l2;
		z = s;
		l2 = 0;
		while (z >= (64'd1 << 31)) begin
			z = z >> 1;
			l2 += 64'd1 << 30;
		end
		for (int i = 29; i >= 0; i--) begin
			z = (z * z) >> 30;
			if (z >= (64'd1 << 31)) begin
				z = z >> 1;
				l2 |= 64'd1 << i;
			end
		end
		return longint'((l2 * longint'(ctc_lcu_pkg::LN2_Q30) +
			(64'd1 << (59 - ctc_lcu_pkg::FRAC_BITS))) >> (60 - ctc_lcu_pkg::FRAC_BITS));
	endfunction

	function automatic longint log_sum_cell(longint a, longint b, longint c, bit skip,
		longint lp);
		longint m;
		longint unsigned s;
		m = (a > b) ? a : b;
		if (skip && c > m) begin
			m = c;
		end
		if (m == longint'(ctc_lcu_pkg::NEG_INF)) begin
			return ctc_lcu_pkg::NEG_INF;
		end
		s = exp_q30(a, m) + exp_q30(b, m) + (skip ? exp_q30(c, m) : 0);
		if (s < (64'd1 << 30)) begin
			return ctc_lcu_pkg::NEG_INF;
		end
		if (lp == longint'(ctc_lcu_pkg::NEG_INF)) begin
			return ctc_lcu_pkg::NEG_INF;
		end
		return clamp32(ln_frac(s) + m + lp);
	endfunction

	function automatic cell_res_t lattice_cell(cell_req_t q, logic dir);
		longint t, slot, il, tl, seq_len, rem, lo, hi, cell_v, upd;
		bit win;
		bit filled;
		cell_res_t r;
		t = q.t;
		slot = q.slot;
		il = q.ilen;
		tl = q.tlen;
		if (il > ctc_lcu_pkg::MAX_TIME) begin
			il = ctc_lcu_pkg::MAX_TIME;
		end
		if (tl > ctc_lcu_pkg::MAX_LABELS) begin
			tl = ctc_lcu_pkg::MAX_LABELS;
		end
		seq_len = 2 * tl + 1;
		rem = il - t;
		lo = (rem > 0 && seq_len > 2 * rem) ? seq_len - 2 * rem : 0;
		hi = (2 * t + 2 < seq_len) ? 2 * t + 2 : seq_len;
		win = slot < seq_len && slot >= lo && slot <= hi;
		cell_v = ctc_lcu_pkg::NEG_INF;
		r.loss = ctc_lcu_pkg::LOSS_NONE;
		filled = 0;
		if (dir == 1'b0) begin
			if (t == 0) begin
				if (slot < 2) begin
					cell_v = q.lp;
				end
				filled = 1;
			end else if (win && t < il) begin
				cell_v = log_sum_cell(q.a, q.b, q.c, q.skip, q.lp);
				filled = 1;
			end
			if (filled && t == il - 1) begin
				if (slot == seq_len - 1) begin
					r.loss = ctc_lcu_pkg::LOSS_BLANK;
				end else if (slot == seq_len - 2) begin
					r.loss = ctc_lcu_pkg::LOSS_LABEL;
				end
			end
		end else begin
			if (t == il - 1 && (slot == seq_len - 1 || slot == seq_len - 2)) begin
				cell_v = q.lp;
			end else if (win && t < il - 1) begin
				cell_v = log_sum_cell(q.a, q.b, q.c, q.skip, q.lp);
			end
		end
		if (cell_v == longint'(ctc_lcu_pkg::NEG_INF) || q.prior == ctc_lcu_pkg::NEG_INF) begin
			upd = ctc_lcu_pkg::NEG_INF;
		end else begin
			upd = clamp32(longint'(q.prior) + cell_v);
		end
		r.cell_val = cell_v[31:0];
		r.upd = upd[31:0];
		return r;
	endfunction

	function automatic table_row_t row(int t, int slot, int ilen, int tlen, int a, int b,
		int c, int skip, int lp, int prior, int typed, int ecell, int eupd, int eloss);
		table_row_t w;
		w.req = '{10'(t), 10'(slot), 11'(ilen), 9'(tlen), a, b, c, 1'(skip), lp, prior};
		w.typed = 1'(typed);
		w.res = '{ecell, eupd, 2'(eloss)};
		return w;
	endfunction

	function automatic logic [31:0] near_value(logic signed [31:0] base);
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			return ctc_lcu_pkg::NEG_INF;
		end
		return base - $signed($urandom_range(0, 32'h0030_0000)) +
			$signed($urandom_range(0, 32'h0008_0000));
	endfunction

	function automatic cell_req_t random_cell();
		cell_req_t q;
		int seq_len;
		logic signed [31:0] base;
		if ($urandom_range(0, 9) < 2) begin
			q.t = 10'($urandom);
			q.slot = 10'($urandom);
			q.ilen = 11'($urandom);
			q.tlen = 9'($urandom);
			q.a = $urandom;
			q.b = $urandom;
			q.c = $urandom;
			q.skip = 1'($urandom);
			q.lp = $urandom;
			q.prior = $urandom;
			return q;
		end
		q.ilen = 11'(($urandom_range(0, 19) == 0) ? $urandom_range(1000, 2047) :
			$urandom_range(1, 40));
		q.tlen = 9'(($urandom_range(0, 19) == 0) ? $urandom_range(200, 511) :
			$urandom_range(0, 20));
		q.t = 10'(($urandom_range(0, 3) == 0) ? q.ilen - 1 :
			$urandom_range(0, q.ilen - 1));
		seq_len = 2 * ((q.tlen > ctc_lcu_pkg::MAX_LABELS) ? ctc_lcu_pkg::MAX_LABELS :
			q.tlen) + 1;
		if ($urandom_range(0, 3) == 0) begin
			q.slot = 10'(seq_len - 1 - $urandom_range(0, 1));
		end else begin
			q.slot = 10'($urandom_range(0, (seq_len < 1024) ? seq_len : 1023));
		end
		base = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0300_0000;
		q.a = near_value(base);
		q.b = near_value(base);
		q.c = near_value(base);
		q.skip = 1'($urandom);
		q.lp = ($urandom_range(0, 15) == 0) ? ctc_lcu_pkg::NEG_INF :
			-$signed($urandom_range(0, 32'h0010_0000));
		q.prior = ($urandom_range(0, 15) == 0) ? ctc_lcu_pkg::NEG_INF :
			$signed($urandom_range(0, 32'h0800_0000)) - 32'sh0700_0000;
		return q;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	task automatic send_cell(cell_req_t q, bit typed, cell_res_t typed_res);
		s_tdata <= {7'd0, q.prior, q.lp, q.skip, q.c, q.b, q.a, q.tlen, q.ilen, q.slot, q.t};
		s_tvalid <= 1'b1;
		@(negedge clk);
		while (!s_tready) begin
			@(negedge clk);
		end
		pending_cells.push_back(typed ? typed_res : lattice_cell(q, pass_dir));
		@(posedge clk);
	endtask

	task automatic idle_gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 8)) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cells.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_pass(logic dir);
		drain();
		repeat (60) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= dir;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pass_dir = dir;
	endtask

	task automatic random_phase(int count);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 10);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_cell(random_cell(), 1'b0, '{32'd0, 32'd0, 2'd0});
				sent++;
			end
			if (sent == count / 2) begin
				drain();
			end
			idle_gap();
		end
	endtask

	// receiver stall pattern in one of four randomly chosen modes
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0) begin
			rx_mode <= $urandom_range(0, 3);
		end
		case (rx_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			2: begin
				m_tready <= (rx_cycle % 4) != 3;
			end
			default: begin
				m_tready <= (rx_cycle % 16) < 3;
			end
		endcase
	end

	always @(negedge clk) begin
		cell_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cells.size() == 0) begin
				report("unexpected beat", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_cells.pop_front();
				if (m_tdata[31:0] !== want.cell_val) begin
					report("cell_value", m_tdata[31:0], want.cell_val);
				end
				if (m_tdata[63:32] !== want.upd) begin
					report("store_updated", m_tdata[63:32], want.upd);
				end
				if (m_tdata[65:64] !== want.loss) begin
					report("loss_slot", {30'd0, m_tdata[65:64]}, {30'd0, want.loss});
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		table_row_t dir_table[$];
		dir_table = '{
			row(0, 0, 5, 3, 0, 0, 0, 0, -65536, 0, 1, -65536, -65536,
				ctc_lcu_pkg::LOSS_NONE),
			row(0, 0, 1, 0, 0, 0, 0, 0, 5, 3, 1, 5, 8, ctc_lcu_pkg::LOSS_BLANK),
			row(0, 1, 1, 1, 0, 0, 0, 0, 7, ctc_lcu_pkg::NEG_INF, 1, 7,
				ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::LOSS_LABEL),
			row(0, 5, 4, 3, 0, 0, 0, 0, 7, 0, 1, ctc_lcu_pkg::NEG_INF,
				ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::LOSS_NONE),
			row(3, 900, 10, 2, 0, 0, 0, 0, 0, 0, 1, ctc_lcu_pkg::NEG_INF,
				ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::LOSS_NONE),
			row(2, 2, 10, 3, ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::NEG_INF,
				ctc_lcu_pkg::NEG_INF, 1, 0, 0, 1, ctc_lcu_pkg::NEG_INF,
				ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::LOSS_NONE),
			row(2, 2, 10, 3, 0, 0, 0, 1, ctc_lcu_pkg::NEG_INF, 0, 1,
				ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::LOSS_NONE),
			row(2, 2, 10, 3, ctc_lcu_pkg::POS_MAX, ctc_lcu_pkg::NEG_INF,
				ctc_lcu_pkg::NEG_INF, 0, ctc_lcu_pkg::POS_MAX, ctc_lcu_pkg::POS_MAX, 1,
				ctc_lcu_pkg::POS_MAX, ctc_lcu_pkg::POS_MAX, ctc_lcu_pkg::LOSS_NONE),
			row(2, 2, 10, 3, ctc_lcu_pkg::NEG_INF + 1, ctc_lcu_pkg::NEG_INF,
				ctc_lcu_pkg::NEG_INF, 0, ctc_lcu_pkg::NEG_INF + 1, 0, 1,
				ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::NEG_INF, ctc_lcu_pkg::LOSS_NONE),
			row(2, 2, 10, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			row(2, 3, 10, 3, 0, -65536, 131072, 1, -32768, 100, 0, 0, 0, 0),
			row(2, 3, 10, 3, 0, -(40 <<< 16), 5, 0, -32768, 100, 0, 0, 0, 0),
			row(4, 7, 5, 3, 65536, 0, 0, 1, -65536, 0, 0, 0, 0, 0),
			row(1023, 1023, 2047, 511, 32'h7fff_0000, 32'h1234_5678, 0, 1, 32'hffff_0000,
				32'h8000_0001, 0, 0, 0, 0),
			row(0, 0, 0, 0, 0, 0, 0, 0, 42, 1, 0, 0, 0, 0),
			row(1, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_pass(1'b0);
		foreach (dir_table[i]) begin
			send_cell(dir_table[i].req, dir_table[i].typed, dir_table[i].res);
		end
		random_phase(200);
		set_pass(1'b1);
		random_phase(200);
		set_pass(1'b0);
		random_phase(200);
		set_pass(1'b1);
		random_phase(200);
		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_cells.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/ctc_lcu_pkg.sv
sv/ctc_lcu_exp_pipe.sv
sv/ctc_lcu_ln_pipe.sv
sv/ctc_lattice_cell_update_core.sv
verif/tb_top.sv
